>>> rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg: shared types and constants for the distance drive controller
// Holds field widths, register indexes, the configuration bundle and the
// control bundle for the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package pdd_pkg;

    // Datapath widths.
    localparam int ERR_W   = 33;  // saturated count error
    localparam int SUM_W   = 34;  // error sum and error difference
    localparam int HERR_W  = 17;  // heading error
    localparam int MUL_A_W = 17;  // multiplier operand A (gains)
    localparam int MUL_B_W = 18;  // multiplier operand B (slices of wide values)
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int MAC_W   = 53;  // accumulator width
    localparam int HI_SH   = 17;  // weight of the upper operand slice

    // Control constants.
    localparam logic [4:0] SETTLE_LIMIT = 5'd30;
    localparam int         ISUM_LIMIT   = 100;
    localparam int         STILL_BAND   = 2;

    // Configuration register indexes.
    localparam logic [2:0] REG_DRIVE_SAT   = 3'd0;
    localparam logic [2:0] REG_KP_DRIVE    = 3'd1;
    localparam logic [2:0] REG_KI_DRIVE    = 3'd2;
    localparam logic [2:0] REG_KD_DRIVE    = 3'd3;
    localparam logic [2:0] REG_FEEDFORWARD = 3'd4;
    localparam logic [2:0] REG_KP_HEADING  = 3'd5;
    localparam logic [2:0] REG_KD_HEADING  = 3'd6;
    localparam logic [2:0] REG_LEFT_COMP   = 3'd7;

    // Configuration bundle seen by the datapath.
    typedef struct packed {
        logic        [14:0] drive_sat;
        logic signed [15:0] kp_drive;
        logic signed [15:0] ki_drive;
        logic signed [15:0] kd_drive;
        logic        [14:0] feedforward;
        logic signed [15:0] kp_heading;
        logic signed [15:0] kd_heading;
        logic        [15:0] left_comp;
    } cfg_t;

    // Commands to the shared multiply-accumulate unit.
    typedef struct packed {
        logic issue;  // start a product this cycle
        logic hi;     // product belongs to the upper operand slice
        logic clear;  // zero the accumulator
    } mac_ctl_t;

endpackage

>>> rtl/pdd_cfg.sv
// ----------------------------------------------------------------------------
// pdd_cfg: configuration register file
// Eight write-only registers written through a plain index/data port.
// ----------------------------------------------------------------------------
module pdd_cfg import pdd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Register writes; each register keeps the bits it is wide.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_sat   <= 15'd32767;
            cfg_reg.kp_drive    <= '0;
            cfg_reg.ki_drive    <= '0;
            cfg_reg.kd_drive    <= '0;
            cfg_reg.feedforward <= '0;
            cfg_reg.kp_heading  <= '0;
            cfg_reg.kd_heading  <= '0;
            cfg_reg.left_comp   <= 16'd16384;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DRIVE_SAT:   cfg_reg.drive_sat   <= cfg_wdata[14:0];
                REG_KP_DRIVE:    cfg_reg.kp_drive    <= cfg_wdata;
                REG_KI_DRIVE:    cfg_reg.ki_drive    <= cfg_wdata;
                REG_KD_DRIVE:    cfg_reg.kd_drive    <= cfg_wdata;
                REG_FEEDFORWARD: cfg_reg.feedforward <= cfg_wdata[14:0];
                REG_KP_HEADING:  cfg_reg.kp_heading  <= cfg_wdata;
                REG_KD_HEADING:  cfg_reg.kd_heading  <= cfg_wdata;
                REG_LEFT_COMP:   cfg_reg.left_comp   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/pdd_mac.sv
// ----------------------------------------------------------------------------
// pdd_mac: shared multiply-accumulate unit
// One 17x18 signed multiplier with a registered product, followed by an
// accumulator that adds the product at weight 1 or 2^17 in the next cycle.
// ----------------------------------------------------------------------------
module pdd_mac import pdd_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mac_ctl_t                  ctl,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [MAC_W-1:0]   acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pv_reg;
    logic                     ps_reg;
    logic signed [MAC_W-1:0]  acc_reg;
    logic signed [MAC_W-1:0]  addend;

    // Scale the registered product to its slice weight.
    always_comb begin
        if (ps_reg) begin
            addend = {{(MAC_W-PROD_W-HI_SH){prod_reg[PROD_W-1]}}, prod_reg, {HI_SH{1'b0}}};
        end else begin
            addend = {{(MAC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Multiplier stage, then accumulate.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        ps_reg   <= ctl.hi;
        if (!aresetn) begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            pv_reg <= ctl.issue;
            if (ctl.clear) begin
                acc_reg <= '0;
            end else if (pv_reg) begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/pid_distance_drive_with_heading_hold_core.sv
// ----------------------------------------------------------------------------
// pid_distance_drive_with_heading_hold_core: distance PID with heading hold
// Drives a two-motor base a set number of encoder counts while holding the
// heading that was seen when the move started.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream: tdata carries target_counts, the encoder
//   count and the gyro heading; tuser is set for the request that starts a
//   move. Each sample produces one result on the m_ stream: tdata carries
//   the left and right drive commands, tuser is the move-done flag.
//   Gains and limits are written through the cfg_ port while the block is
//   idle; they take effect on the next sample.
//   A start request, or a sample while no move runs, goes from acceptance
//   through the send state to the output register. A sample during a move
//   steps through the error, gain-product, drain, power, heading, turn,
//   left and output states, set by the nine products through the single
//   shared 17x18 multiplier, its two-stage accumulator pipeline and the
//   hand-off. The input is ready again only once the result is registered.
//   The input is accepted again while a result still waits in the output
//   register; if the receiver stalls, the next result holds in the
//   sequencer until the output register frees.
//   Reset is synchronous and active low: it restores the default gains,
//   stops any move and empties the output register.
// ----------------------------------------------------------------------------
module pid_distance_drive_with_heading_hold_core import pdd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Sample stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // target_counts[23:0], encoder_count[55:24], heading[71:56]
    input  logic        s_tuser,   // begin_move[0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_drive[15:0], right_drive[31:16]
    output logic        m_tuser,   // move_done[0]
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [17:0] {
        ST_IDLE   = 18'b000000000000000001,
        ST_ERR    = 18'b000000000000000010,
        ST_KP_LO  = 18'b000000000000000100,
        ST_KP_HI  = 18'b000000000000001000,
        ST_KD_LO  = 18'b000000000000010000,
        ST_KD_HI  = 18'b000000000000100000,
        ST_KI_LO  = 18'b000000000001000000,
        ST_KI_HI  = 18'b000000000010000000,
        ST_DRAIN  = 18'b000000000100000000,
        ST_POWER  = 18'b000000001000000000,
        ST_HP     = 18'b000000010000000000,
        ST_HD     = 18'b000000100000000000,
        ST_DRAIN2 = 18'b000001000000000000,
        ST_TURN   = 18'b000010000000000000,
        ST_LEFT   = 18'b000100000000000000,
        ST_DRAIN3 = 18'b001000000000000000,
        ST_OUT    = 18'b010000000000000000,
        ST_SEND   = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    cfg_t                      cfg;
    mac_ctl_t                  mac_ctl;
    logic signed [MUL_A_W-1:0] mac_a;
    logic signed [MUL_B_W-1:0] mac_b;
    logic signed [MAC_W-1:0]   mac_acc;

    // Latched sample and move state.
    logic signed [31:0]       enc_reg;
    logic signed [15:0]       hd_reg;
    logic signed [31:0]       start_pos_reg;
    logic signed [23:0]       goal_reg;
    logic signed [15:0]       hsp_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic signed [SUM_W-1:0]  accum_reg;
    logic signed [HERR_W-1:0] last_herr_reg;
    logic [4:0]               settle_reg;
    logic                     moving_reg;

    // Per-sample working registers.
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [HERR_W-1:0] terr_reg;
    logic signed [SUM_W-1:0]  diff_reg;
    logic signed [17:0]       hdiff_reg;
    logic signed [15:0]       p_reg;
    logic signed [16:0]       turn_reg;
    logic signed [15:0]       left_res_reg;
    logic signed [15:0]       right_res_reg;
    logic                     done_res_reg;

    // Output register.
    logic                     m_valid_reg;
    logic [15:0]              m_left_reg;
    logic [15:0]              m_right_reg;
    logic                     m_done_reg;

    // Input fields.
    logic signed [23:0] in_tgt;
    logic signed [31:0] in_enc;
    logic signed [15:0] in_hd;
    logic               in_fire;
    logic               out_free;
    logic [15:0]        sat16;

    assign in_tgt   = s_tdata[23:0];
    assign in_enc   = s_tdata[55:24];
    assign in_hd    = s_tdata[71:56];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign sat16    = {1'b0, cfg.drive_sat};

    pdd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (mac_acc)
    );

    // Count error, saturated to 33 bits, and heading error.
    logic signed [32:0]      rel_pos;
    logic signed [33:0]      err_wide;
    logic signed [ERR_W-1:0] err_sat;
    logic signed [HERR_W-1:0] terr_now;

    always_comb begin
        rel_pos  = {enc_reg[31], enc_reg} - {start_pos_reg[31], start_pos_reg};
        err_wide = {{10{goal_reg[23]}}, goal_reg} - {rel_pos[32], rel_pos};
        if (err_wide[33] != err_wide[32]) begin
            err_sat = err_wide[33] ? {1'b1, 32'b0} : {1'b0, {32{1'b1}}};
        end else begin
            err_sat = err_wide[32:0];
        end
        terr_now = {hsp_reg[15], hsp_reg} - {hd_reg[15], hd_reg};
    end

    // Sign-extended copies used across the schedule.
    logic signed [SUM_W-1:0] err34;
    logic signed [SUM_W-1:0] last34;

    // Power minus turn, the operand of the left-side scaling.
    logic signed [17:0]      drive_diff;

    assign err34  = {err_reg[ERR_W-1], err_reg};
    assign last34 = {last_err_reg[ERR_W-1], last_err_reg};

    // Operand selection for the shared multiplier.
    always_comb begin
        mac_ctl = '0;
        mac_a   = '0;
        mac_b   = '0;
        case (state_reg)
            ST_ERR, ST_POWER, ST_TURN: begin
                mac_ctl.clear = 1'b1;
            end
            ST_KP_LO: begin
                mac_ctl.issue = 1'b1;
                mac_a = {cfg.kp_drive[15], cfg.kp_drive};
                mac_b = {1'b0, err34[HI_SH-1:0]};
            end
            ST_KP_HI: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.hi    = 1'b1;
                mac_a = {cfg.kp_drive[15], cfg.kp_drive};
                mac_b = {err34[SUM_W-1], err34[SUM_W-1:HI_SH]};
            end
            ST_KD_LO: begin
                mac_ctl.issue = 1'b1;
                mac_a = {cfg.kd_drive[15], cfg.kd_drive};
                mac_b = {1'b0, diff_reg[HI_SH-1:0]};
            end
            ST_KD_HI: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.hi    = 1'b1;
                mac_a = {cfg.kd_drive[15], cfg.kd_drive};
                mac_b = {diff_reg[SUM_W-1], diff_reg[SUM_W-1:HI_SH]};
            end
            ST_KI_LO: begin
                mac_ctl.issue = 1'b1;
                mac_a = {cfg.ki_drive[15], cfg.ki_drive};
                mac_b = {1'b0, accum_reg[HI_SH-1:0]};
            end
            ST_KI_HI: begin
                mac_ctl.issue = 1'b1;
                mac_ctl.hi    = 1'b1;
                mac_a = {cfg.ki_drive[15], cfg.ki_drive};
                mac_b = {accum_reg[SUM_W-1], accum_reg[SUM_W-1:HI_SH]};
            end
            ST_HP: begin
                mac_ctl.issue = 1'b1;
                mac_a = {cfg.kp_heading[15], cfg.kp_heading};
                mac_b = {terr_reg[HERR_W-1], terr_reg};
            end
            ST_HD: begin
                mac_ctl.issue = 1'b1;
                mac_a = {cfg.kd_heading[15], cfg.kd_heading};
                mac_b = hdiff_reg;
            end
            ST_LEFT: begin
                mac_ctl.issue = 1'b1;
                mac_a = {1'b0, cfg.left_comp};
                mac_b = drive_diff;
            end
            default: ;
        endcase
    end

    // Drive power: scaled PID sum plus feed-forward signed by the error, clipped.
    logic signed [44:0]      p_base;
    logic signed [45:0]      p_raw;
    logic signed [45:0]      ff46;
    logic signed [45:0]      sat46;
    logic signed [15:0]      p_clip;
    logic signed [SUM_W-1:0] accum_cl;
    logic signed [SUM_W-1:0] pair_sum;
    logic                    still;

    always_comb begin
        p_base = mac_acc[MAC_W-1:8];
        ff46   = {31'b0, cfg.feedforward};
        sat46  = {31'b0, cfg.drive_sat};
        if (err_reg[ERR_W-1]) begin
            p_raw = {p_base[44], p_base} - ff46;
        end else begin
            p_raw = {p_base[44], p_base} + ff46;
        end
        if (p_raw > sat46) begin
            p_clip = sat16;
        end else if (p_raw < -sat46) begin
            p_clip = -sat16;
        end else begin
            p_clip = p_raw[15:0];
        end

        // Integral clamp before the new error is added.
        if (accum_reg > SUM_W'(ISUM_LIMIT)) begin
            accum_cl = SUM_W'(ISUM_LIMIT);
        end else if (accum_reg < -SUM_W'(ISUM_LIMIT)) begin
            accum_cl = -SUM_W'(ISUM_LIMIT);
        end else begin
            accum_cl = accum_reg;
        end

        // Near-still test on consecutive errors.
        pair_sum = err34 + last34;
        still    = (err_reg == last_err_reg)
                || ((pair_sum <= SUM_W'(STILL_BAND)) && (pair_sum >= -SUM_W'(STILL_BAND)));
    end

    // Heading term clipped to the power magnitude.
    logic signed [44:0] t_base;
    logic signed [16:0] p17;
    logic signed [16:0] ap17;
    logic signed [44:0] ap45;
    logic signed [16:0] turn_clip;

    always_comb begin
        t_base = mac_acc[MAC_W-1:8];
        p17    = {p_reg[15], p_reg};
        ap17   = p_reg[15] ? -p17 : p17;
        ap45   = {{28{ap17[16]}}, ap17};
        if (t_base > ap45) begin
            turn_clip = ap17;
        end else if (t_base < -ap45) begin
            turn_clip = -ap17;
        end else begin
            turn_clip = t_base[16:0];
        end
    end

    // Side mixing: left gets power minus turn, right power plus turn.
    logic signed [17:0] drive_sum;
    logic signed [15:0] right_clip;
    logic signed [38:0] l_base;
    logic signed [15:0] left_clip;

    always_comb begin
        drive_diff = {{2{p_reg[15]}}, p_reg} - {turn_reg[16], turn_reg};
        drive_sum  = {{2{p_reg[15]}}, p_reg} + {turn_reg[16], turn_reg};
        if (drive_sum > 18'sd32767) begin
            right_clip = 16'sh7FFF;
        end else if (drive_sum < -18'sd32768) begin
            right_clip = 16'sh8000;
        end else begin
            right_clip = drive_sum[15:0];
        end
        l_base = mac_acc[MAC_W-1:14];
        if (l_base > 39'sd32767) begin
            left_clip = 16'sh7FFF;
        end else if (l_base < -39'sd32768) begin
            left_clip = 16'sh8000;
        end else begin
            left_clip = l_base[15:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (!s_tuser && moving_reg) ? ST_ERR : ST_SEND;
                end
            end
            ST_ERR:    state_next = ST_KP_LO;
            ST_KP_LO:  state_next = ST_KP_HI;
            ST_KP_HI:  state_next = ST_KD_LO;
            ST_KD_LO:  state_next = ST_KD_HI;
            ST_KD_HI:  state_next = ST_KI_LO;
            ST_KI_LO:  state_next = ST_KI_HI;
            ST_KI_HI:  state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_POWER;
            ST_POWER:  state_next = ST_HP;
            ST_HP:     state_next = ST_HD;
            ST_HD:     state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_TURN;
            ST_TURN:   state_next = ST_LEFT;
            ST_LEFT:   state_next = ST_DRAIN3;
            ST_DRAIN3: state_next = ST_OUT;
            ST_OUT:    state_next = ST_SEND;
            ST_SEND: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Move state and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            moving_reg    <= 1'b0;
            settle_reg    <= '0;
            start_pos_reg <= '0;
            goal_reg      <= '0;
            hsp_reg       <= '0;
            last_err_reg  <= '0;
            accum_reg     <= '0;
            last_herr_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        enc_reg <= in_enc;
                        hd_reg  <= in_hd;
                        if (s_tuser) begin
                            // Start request: latch references and drive flat out.
                            start_pos_reg <= in_enc;
                            goal_reg      <= in_tgt;
                            hsp_reg       <= in_hd;
                            last_err_reg  <= '0;
                            accum_reg     <= '0;
                            last_herr_reg <= '0;
                            settle_reg    <= '0;
                            moving_reg    <= 1'b1;
                            left_res_reg  <= in_tgt[23] ? -sat16 : sat16;
                            right_res_reg <= in_tgt[23] ? -sat16 : sat16;
                            done_res_reg  <= 1'b0;
                        end else begin
                            // Idle sample (overwritten by the run when moving).
                            left_res_reg  <= '0;
                            right_res_reg <= '0;
                            done_res_reg  <= (settle_reg >= SETTLE_LIMIT);
                        end
                    end
                end
                ST_ERR: begin
                    err_reg  <= err_sat;
                    terr_reg <= terr_now;
                end
                ST_KP_LO: begin
                    diff_reg  <= err34 - last34;
                    hdiff_reg <= {terr_reg[HERR_W-1], terr_reg}
                               - {last_herr_reg[HERR_W-1], last_herr_reg};
                end
                ST_POWER: begin
                    p_reg        <= p_clip;
                    accum_reg    <= accum_cl + err34;
                    last_err_reg <= err_reg;
                    if (still) begin
                        settle_reg <= settle_reg + 5'd1;
                    end
                end
                ST_TURN: begin
                    turn_reg      <= turn_clip;
                    last_herr_reg <= terr_reg;
                end
                ST_LEFT: begin
                    right_res_reg <= right_clip;
                end
                ST_OUT: begin
                    if (settle_reg >= SETTLE_LIMIT) begin
                        // Settled: stop the move and report done.
                        moving_reg    <= 1'b0;
                        left_res_reg  <= '0;
                        right_res_reg <= '0;
                        done_res_reg  <= 1'b1;
                    end else begin
                        left_res_reg <= left_clip;
                        done_res_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_SEND) && out_free) begin
            m_valid_reg <= 1'b1;
            m_left_reg  <= left_res_reg;
            m_right_reg <= right_res_reg;
            m_done_reg  <= done_res_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_right_reg, m_left_reg};
    assign m_tuser  = m_done_reg;

endmodule
